### src/rgrf_pkg.sv
// Shared constants for the range-gap ray filter.
// No dependencies; every other file of the block but rgrf_sqrt_cell uses this package.
`timescale 1ns / 1ps
`default_nettype none
package rgrf_pkg;
    localparam int COORD_BITS_DEF  = 24;
    localparam int INDEX_BITS      = 24;
    localparam int GAP_THR_BITS    = 10;
    localparam int GAP_SCALE       = 100;
    localparam int GAP_THR_RESET   = 4;
    localparam int THR_SCALED_BITS = 17;
endpackage
`default_nettype wire

### src/rgrf_ifs.sv
// Request channels of the range-gap ray filter: ray input and keep decision output.
// Depends on rgrf_pkg for the index width and the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none
interface rgrf_ray_if #(
    parameter int COORD_BITS = rgrf_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic                         bounded;
    logic                         first_of_cloud;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               bounded, first_of_cloud,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               bounded, first_of_cloud,
        output ready
    );
endinterface

interface rgrf_dec_if;
    import rgrf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  keep;
    logic [INDEX_BITS-1:0] ray_index;

    modport source (output valid, keep, ray_index, input ready);
    modport sink   (input valid, keep, ray_index, output ready);
endinterface
`default_nettype wire

### src/range_gap_ray_filter_core.sv
// Top level of the range-gap ray filter: distance unit, square root cell chain, window.
// Depends on rgrf_pkg, rgrf_ifs, rgrf_dist and rgrf_sqrt_cell.
//
// Usage:
//   i_ray carries one ray request (start, end, bounded, first_of_cloud); it is
//   taken when valid and ready are both high. o_dec carries one keep decision
//   with the index of the middle ray of the three-ray window.
//   i_cfg_we/i_cfg_wdata write the gap threshold in cm (reset value 4); write
//   it only while no ray is in flight.
//   One ray is in flight at a time. A ray passes three distance stages, one
//   square root cell per result bit (COORD_BITS + 1 cells) and three window
//   stages before its decision shows on o_dec; the next ray is taken only once
//   the filter is idle again, after that decision is placed.
//   The first and last ray of each cloud give no decision.
//   Reset empties the window, clears the index and the output register and
//   restores the threshold.
//   A stalled receiver holds the decision in the output register; the next ray
//   still runs, then its decision and any further request wait for the register.
`timescale 1ns / 1ps
`default_nettype none
module range_gap_ray_filter_core #(
    parameter int COORD_BITS = rgrf_pkg::COORD_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [rgrf_pkg::GAP_THR_BITS-1:0] i_cfg_wdata,
    rgrf_ray_if.sink                          i_ray,
    rgrf_dec_if.source                        o_dec
);
    import rgrf_pkg::*;

    localparam int RB       = COORD_BITS + 1;
    localparam int CMP_BITS = (RB > THR_SCALED_BITS) ? RB : THR_SCALED_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DIFF,
        S_DECIDE
    } t_state;

    t_state                     r_state;
    logic [THR_SCALED_BITS-1:0] r_gap_thr;
    logic                       r_bounded;
    logic                       r_first;
    logic [RB-1:0]              r_range;
    logic [RB-1:0]              r_older_range;
    logic [RB-1:0]              r_newer_range;
    logic                       r_newer_bounded;
    logic [1:0]                 r_fill;
    logic [INDEX_BITS-1:0]      r_ray_counter;
    logic [RB-1:0]              r_d0, r_d1, r_d2;
    logic                       r_have;
    logic                       r_out_valid;
    logic                       r_out_keep;
    logic [INDEX_BITS-1:0]      r_out_index;

    logic                       w_accept;
    logic                       w_dist_vld;
    logic [2*RB-1:0]            w_dist_sum;
    logic [RB:0]                w_vld;
    logic [2*RB-1:0]            w_rad  [0:RB];
    logic [RB:0]                w_rem  [0:RB];
    logic [RB-1:0]              w_root [0:RB];
    logic [1:0]                 w_fill_eff;
    logic [RB-1:0]              w_mn01, w_mn;
    logic                       w_keep;
    logic                       w_out_free;
    logic                       w_emit;

    assign i_ray.ready = (r_state == S_IDLE);
    assign w_accept    = i_ray.valid && i_ray.ready;

    rgrf_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_accept),
        .i_start_x (i_ray.start_x),
        .i_start_y (i_ray.start_y),
        .i_start_z (i_ray.start_z),
        .i_end_x   (i_ray.end_x),
        .i_end_y   (i_ray.end_y),
        .i_end_z   (i_ray.end_z),
        .o_valid   (w_dist_vld),
        .o_sum     (w_dist_sum)
    );

    assign w_vld[0]  = w_dist_vld;
    assign w_rad[0]  = w_dist_sum;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < RB; k++) begin : g_cell
        rgrf_sqrt_cell #(
            .RB (RB)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[k]),
            .i_rad   (w_rad[k]),
            .i_rem   (w_rem[k]),
            .i_root  (w_root[k]),
            .o_valid (w_vld[k+1]),
            .o_rad   (w_rad[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_root  (w_root[k+1])
        );
    end

    assign w_fill_eff = r_first ? 2'd0 : r_fill;
    assign w_mn01     = (r_d1 < r_d0) ? r_d1 : r_d0;
    assign w_mn       = (r_d2 < w_mn01) ? r_d2 : w_mn01;
    assign w_keep     = !r_newer_bounded || (CMP_BITS'(w_mn) < CMP_BITS'(r_gap_thr));
    assign w_out_free = !r_out_valid || o_dec.ready;
    assign w_emit     = (r_state == S_DECIDE) && r_have && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_gap_thr       <= THR_SCALED_BITS'(GAP_THR_RESET * GAP_SCALE);
            r_older_range   <= '0;
            r_newer_range   <= '0;
            r_newer_bounded <= 1'b0;
            r_fill          <= 2'd0;
            r_ray_counter   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap_thr <= THR_SCALED_BITS'(i_cfg_wdata * GAP_SCALE);
            end
            if (o_dec.valid && o_dec.ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_bounded <= i_ray.bounded;
                        r_first   <= i_ray.first_of_cloud;
                        r_state   <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_vld[RB]) begin
                        r_range <= w_root[RB];
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_d0    <= (r_older_range > r_range) ? r_older_range - r_range
                                                         : r_range - r_older_range;
                    r_d1    <= (r_newer_range > r_older_range) ? r_newer_range - r_older_range
                                                               : r_older_range - r_newer_range;
                    r_d2    <= (r_range > r_newer_range) ? r_range - r_newer_range
                                                         : r_newer_range - r_range;
                    r_have  <= (w_fill_eff == 2'd2);
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (!r_have || w_out_free) begin
                        if (r_have) begin
                            r_out_valid <= 1'b1;
                            r_out_keep  <= w_keep;
                            r_out_index <= r_ray_counter;
                        end
                        if (w_fill_eff == 2'd0) begin
                            r_ray_counter <= '0;
                        end else if (r_ray_counter != '1) begin
                            r_ray_counter <= r_ray_counter + 1'b1;
                        end
                        r_older_range   <= r_newer_range;
                        r_newer_range   <= r_range;
                        r_newer_bounded <= r_bounded;
                        r_fill          <= (w_fill_eff == 2'd2) ? 2'd2 : w_fill_eff + 2'd1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_dec.valid     = r_out_valid;
    assign o_dec.keep      = r_out_keep;
    assign o_dec.ray_index = r_out_index;

    a_root_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[RB] |-> (r_state == S_RUN))
        else $error("square root result outside the run state");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) <= 1)
        else $error("more than one ray in the cell chain");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_vld == '0))
        else $error("cell chain busy while idle");

    a_decide_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_have && !r_out_valid) |=> r_out_valid)
        else $error("decision not placed in a free output register");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && !r_have) |=> !$rose(r_out_valid))
        else $error("decision issued with a partial window");
endmodule
`default_nettype wire

### src/rgrf_dist.sv
// Squared ray length: coordinate differences, squares and their sum in three stages.
// Depends on rgrf_pkg only through the default coordinate width.
`timescale 1ns / 1ps
`default_nettype none
module rgrf_dist #(
    parameter int COORD_BITS = rgrf_pkg::COORD_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    input  wire  signed [COORD_BITS-1:0]  i_start_x,
    input  wire  signed [COORD_BITS-1:0]  i_start_y,
    input  wire  signed [COORD_BITS-1:0]  i_start_z,
    input  wire  signed [COORD_BITS-1:0]  i_end_x,
    input  wire  signed [COORD_BITS-1:0]  i_end_y,
    input  wire  signed [COORD_BITS-1:0]  i_end_z,
    output logic                          o_valid,
    output logic [2*(COORD_BITS+1)-1:0]   o_sum
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * DW;

    logic signed [DW-1:0] w_dx, w_dy, w_dz;
    logic [DW-1:0]        r_mag_x, r_mag_y, r_mag_z;
    logic [SW-1:0]        r_sq_x, r_sq_y, r_sq_z;
    logic [SW-1:0]        r_sum;
    logic                 r_v1, r_v2, r_v3;

    assign w_dx = DW'(i_end_x) - DW'(i_start_x);
    assign w_dy = DW'(i_end_y) - DW'(i_start_y);
    assign w_dz = DW'(i_end_z) - DW'(i_start_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_mag_x <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
        r_mag_y <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
        r_mag_z <= w_dz[DW-1] ? DW'(-w_dz) : DW'(w_dz);
        r_sq_x  <= SW'(r_mag_x) * SW'(r_mag_x);
        r_sq_y  <= SW'(r_mag_y) * SW'(r_mag_y);
        r_sq_z  <= SW'(r_mag_z) * SW'(r_mag_z);
        r_sum   <= r_sq_x + r_sq_y + r_sq_z;
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum;
endmodule
`default_nettype wire

### src/rgrf_sqrt_cell.sv
// One digit cell of the integer square root chain: one result bit per cell.
// No package dependencies; the chain is built in the top level.
`timescale 1ns / 1ps
`default_nettype none
module rgrf_sqrt_cell #(
    parameter int RB = 25
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  wire  [2*RB-1:0]   i_rad,
    input  wire  [RB:0]       i_rem,
    input  wire  [RB-1:0]     i_root,
    output logic              o_valid,
    output logic [2*RB-1:0]   o_rad,
    output logic [RB:0]       o_rem,
    output logic [RB-1:0]     o_root
);
    logic              r_valid;
    logic [2*RB-1:0]   r_rad;
    logic [RB:0]       r_rem;
    logic [RB-1:0]     r_root;
    logic [RB+2:0]     w_work;
    logic [RB+2:0]     w_trial;
    logic              w_ge;

    assign w_work  = {i_rem, i_rad[2*RB-1 -: 2]};
    assign w_trial = (RB+3)'({i_root, 2'b01});
    assign w_ge    = (w_work >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        if (i_valid) begin
            r_rad  <= {i_rad[2*RB-3:0], 2'b00};
            r_rem  <= w_ge ? (RB+1)'(w_work - w_trial) : (RB+1)'(w_work);
            r_root <= {i_root[RB-2:0], w_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
endmodule
`default_nettype wire

### tb/range_gap_ray_filter_core_tb.sv
// Testbench for range_gap_ray_filter_core: directed and random ray clouds under varied idling.
// A scoreboard class predicts keep decisions; depends on rgrf_pkg, rgrf_ifs and the core.
`timescale 1ns / 1ps
module range_gap_ray_filter_core_tb;
    import rgrf_pkg::*;

    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int LATENCY      = COORD_BITS + 8;
    localparam int DRAIN_CYCLES = 2 * LATENCY;
    localparam int MAX_REPORTS  = 10;
    localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));
    localparam int COORD_HALF   = 1 << (COORD_BITS - 2);
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int TIMEOUT_NS   = 5_000_000;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord sx, sy, sz, ex, ey, ez;
        logic   bounded;
        logic   first;
    } t_ray;

    typedef struct {
        logic                  keep;
        logic [INDEX_BITS-1:0] ray_index;
    } t_decision;

    class t_decision_board;
        logic [GAP_THR_BITS-1:0] thr_cm;
        longint unsigned         older_rng;
        longint unsigned         newer_rng;
        logic                    newer_bnd;
        int unsigned             fill;
        logic [INDEX_BITS-1:0]   ray_no;
        t_decision               pending[$];
        int unsigned             faults;

        function new();
            thr_cm    = GAP_THR_BITS'(GAP_THR_RESET);
            older_rng = 0;
            newer_rng = 0;
            newer_bnd = 1'b0;
            fill      = 0;
            ray_no    = '0;
            faults    = 0;
        endfunction

        static function longint unsigned floor_root(longint unsigned n);
            longint unsigned rem, root, bitv;
            rem  = n;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv >>= 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root >>= 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        static function longint unsigned span_sq(t_coord a, t_coord b);
            longint d;
            d = longint'(b) - longint'(a);
            return $unsigned(d * d);
        endfunction

        static function longint unsigned gap_between(longint unsigned a, longint unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function void take_ray(t_ray r);
            longint unsigned rng, mn, lim;
            t_decision       d;
            rng = floor_root(span_sq(r.sx, r.ex) + span_sq(r.sy, r.ey) + span_sq(r.sz, r.ez));
            if (r.first)
                fill = 0;
            if (fill >= 2) begin
                mn = gap_between(older_rng, rng);
                if (gap_between(newer_rng, older_rng) < mn)
                    mn = gap_between(newer_rng, older_rng);
                if (gap_between(rng, newer_rng) < mn)
                    mn = gap_between(rng, newer_rng);
                lim = longint'(thr_cm) * GAP_SCALE;
                d.keep      = !newer_bnd || (mn < lim);
                d.ray_index = ray_no;
                pending.push_back(d);
            end
            if (fill == 0)
                ray_no = '0;
            else if (ray_no != '1)
                ray_no++;
            older_rng = newer_rng;
            newer_rng = rng;
            newer_bnd = r.bounded;
            if (fill < 2)
                fill++;
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void match_decision(logic keep, logic [INDEX_BITS-1:0] idx);
            t_decision want;
            if (pending.size() == 0) begin
                note_fault($sformatf("decision with none pending: keep=%0d index=%0d",
                                     keep, idx));
                return;
            end
            want = pending.pop_front();
            if (want.keep !== keep || want.ray_index !== idx)
                note_fault($sformatf(
                    "mismatch: expected keep=%0d index=%0d, got keep=%0d index=%0d",
                    want.keep, want.ray_index, keep, idx));
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [GAP_THR_BITS-1:0] cfg_wdata;
    int                      ray_idle_pct;
    int                      dec_stall_pct;
    t_decision_board         board;

    rgrf_ray_if #(.COORD_BITS(COORD_BITS)) ray_ch ();
    rgrf_dec_if dec_ch ();

    range_gap_ray_filter_core #(.COORD_BITS(COORD_BITS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_ray       (ray_ch),
        .o_dec       (dec_ch)
    );

    function automatic t_ray make_ray(int sx, int sy, int sz, int ex, int ey, int ez,
                                      logic b, logic f);
        t_ray r;
        r.sx = t_coord'(sx);
        r.sy = t_coord'(sy);
        r.sz = t_coord'(sz);
        r.ex = t_coord'(ex);
        r.ey = t_coord'(ey);
        r.ez = t_coord'(ez);
        r.bounded = b;
        r.first   = f;
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        dec_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            dec_ch.ready <= ($urandom_range(0, 99) >= dec_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_ray seen;
        if (i_rst_n && ray_ch.valid && ray_ch.ready) begin
            seen.sx      = ray_ch.start_x;
            seen.sy      = ray_ch.start_y;
            seen.sz      = ray_ch.start_z;
            seen.ex      = ray_ch.end_x;
            seen.ey      = ray_ch.end_y;
            seen.ez      = ray_ch.end_z;
            seen.bounded = ray_ch.bounded;
            seen.first   = ray_ch.first_of_cloud;
            board.take_ray(seen);
        end
        if (i_rst_n && dec_ch.valid && dec_ch.ready)
            board.match_decision(dec_ch.keep, dec_ch.ray_index);
    end

    // enter and leave at a falling edge
    task automatic send_ray(input t_ray r);
        while ($urandom_range(0, 99) < ray_idle_pct) begin
            ray_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        ray_ch.start_x        <= r.sx;
        ray_ch.start_y        <= r.sy;
        ray_ch.start_z        <= r.sz;
        ray_ch.end_x          <= r.ex;
        ray_ch.end_y          <= r.ey;
        ray_ch.end_z          <= r.ez;
        ray_ch.bounded        <= r.bounded;
        ray_ch.first_of_cloud <= r.first;
        ray_ch.valid          <= 1'b1;
        @(posedge i_clk);
        while (!ray_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off requests until every decision is in and the pipe is empty
    task automatic settle();
        ray_ch.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_gap_threshold(input logic [GAP_THR_BITS-1:0] thr);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= thr;
        @(posedge i_clk);
        board.thr_cm = thr;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_clouds(input int n_items);
        int     sent, len, base, jit, scale, pick, axis, k;
        int     d[3];
        t_coord s[3];
        t_coord e[3];
        logic   noisy, b;
        sent = 0;
        while (sent < n_items) begin
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 14);
            noisy = ($urandom_range(0, 99) < 15);
            base  = $urandom_range(0, 2900000);
            scale = board.thr_cm * GAP_SCALE;
            pick  = $urandom_range(0, 2);
            jit   = (pick == 0) ? scale / 2 + 1 :
                    (pick == 1) ? 2 * scale + 10 : $urandom_range(0, 1000000);
            axis  = $urandom_range(0, 2);
            for (int i = 0; i < len; i++) begin
                for (k = 0; k < 3; k++) begin
                    if (noisy) begin
                        s[k] = t_coord'($urandom);
                        e[k] = t_coord'($urandom);
                    end else begin
                        s[k] = t_coord'($urandom_range(0, 2 * COORD_HALF - 1) - COORD_HALF);
                        d[k] = $urandom_range(0, 4000) - 2000;
                        if (k == axis)
                            d[k] = base + $urandom_range(0, 2 * jit) - jit;
                        if ($urandom_range(0, 19) == 0)
                            d[k] = d[k] + $urandom_range(0, 200000);
                        e[k] = t_coord'(s[k] + d[k]);
                    end
                end
                b = noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 80);
                send_ray(make_ray(int'(s[0]), int'(s[1]), int'(s[2]),
                                  int'(e[0]), int'(e[1]), int'(e[2]), b, i == 0));
                sent++;
            end
        end
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        board                 = new();
        ray_idle_pct          = 0;
        dec_stall_pct         = 0;
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        ray_ch.valid          = 1'b0;
        ray_ch.start_x        = '0;
        ray_ch.start_y        = '0;
        ray_ch.start_z        = '0;
        ray_ch.end_x          = '0;
        ray_ch.end_y          = '0;
        ray_ch.end_z          = '0;
        ray_ch.bounded        = 1'b0;
        ray_ch.first_of_cloud = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // gaps around the reset threshold, unbounded middle, extremes
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 1'b1, 1'b1));
        send_ray(make_ray(0, 0, 0, 400, 0, 0, 1'b1, 1'b0));
        send_ray(make_ray(0, 0, 0, 800, 0, 0, 1'b1, 1'b0));
        send_ray(make_ray(0, 0, 0, 1199, 0, 0, 1'b1, 1'b0));
        send_ray(make_ray(0, 0, 0, 50000, 0, 0, 1'b0, 1'b0));
        send_ray(make_ray(0, 0, 0, 900000, 0, 0, 1'b1, 1'b0));
        send_ray(make_ray(0, 0, 0, 2000000, 0, 0, 1'b1, 1'b0));
        send_ray(make_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                          1'b1, 1'b0));
        send_ray(make_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                          1'b1, 1'b0));
        send_ray(make_ray(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          1'b0, 1'b0));
        send_ray(make_ray(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                          1'b1, 1'b0));
        send_ray(make_ray(-5, 0, 0, 395, 0, 0, 1'b1, 1'b0));
        // one-ray and two-ray clouds give no decision, then a seven-ray cloud
        send_ray(make_ray(100, -200, 300, 100, -200, 423, 1'b1, 1'b1));
        send_ray(make_ray(0, 0, 0, 7, 0, 0, 1'b1, 1'b1));
        send_ray(make_ray(0, 0, 0, 0, 8, 0, 1'b1, 1'b0));
        send_ray(make_ray(0, 0, 0, 300, 400, 0, 1'b1, 1'b1));
        send_ray(make_ray(10, 10, 10, 7, 6, -2, 1'b1, 1'b0));
        send_ray(make_ray(0, 0, 0, 0, 0, -899, 1'b1, 1'b0));
        send_ray(make_ray(-1000, 2000, -3000, -1000, 2000, -2601, 1'b1, 1'b0));
        send_ray(make_ray(0, 0, 0, 1, 1, 1, 1'b0, 1'b0));
        send_ray(make_ray(0, 0, 0, COORD_MAX, 0, 0, 1'b1, 1'b0));
        send_ray(make_ray(0, 0, 0, 0, COORD_MIN, 0, 1'b1, 1'b0));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       set_gap_threshold('0);
                1:       set_gap_threshold('1);
                2:       set_gap_threshold(GAP_THR_BITS'(1));
                3:       set_gap_threshold(GAP_THR_BITS'(1000));
                default: set_gap_threshold(GAP_THR_BITS'($urandom_range(1, 1023)));
            endcase
            ray_idle_pct  = (p % 4 == 1) ? 74 : (p % 4 == 3) ? 26 : 0;
            dec_stall_pct = (p % 4 == 2) ? 74 : (p % 4 == 3) ? 26 : 0;
            run_clouds(PHASE_ITEMS);
        end

        settle();
        if (board.faults == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
